// File: hw/rtl/srlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlr_pkg
// Shared types and constants for the stuffed run-length frame receiver.
// ----------------------------------------------------------------------------
package srlr_pkg;

    // Configuration register indexes.
    typedef enum logic {
        CFG_BIT_TIME  = 1'b0,
        CFG_IDLE_BITS = 1'b1
    } t_cfg_idx;

    // Receive phase as reported on every result beat.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_MSG   = 3'd2,
        PH_LEN   = 3'd3,
        PH_ERROR = 3'd4
    } t_phase;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_BITS,
        ST_DRAIN
    } t_seq_state;

    // Request types on the input channel.
    localparam logic REQ_EDGE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam logic [7:0] BIT_TIME_RST  = 8'd20;
    localparam logic [3:0] IDLE_BITS_RST = 4'd7;
    localparam logic [7:0] LEN_MASK      = 8'b0000_1111;
    localparam logic [3:0] STUFF_RUN     = 4'd5;
    localparam logic [3:0] STUFF_LIMIT   = 4'd6;
    localparam logic [2:0] TOP_BIT       = 3'd7;
    localparam logic [3:0] FULL_BITS     = 4'd8;

    // Depth of the per-item result buffer; one input item causes at most two result beats.
    localparam int QDEPTH = 3;

    typedef struct packed {
        logic       req_type;
        logic       line_level;
        logic [7:0] elapsed_ticks;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic [3:0] bits_valid;
        logic       frame_end;
        logic [3:0] message_length;
        logic [2:0] receive_state;
        logic       last_in_run;
    } t_out_item;

    // A result waiting for the phase at the end of its item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic [3:0] bits_valid;
        logic       frame_end;
        logic [3:0] message_length;
    } t_qent;

endpackage

// File: hw/rtl/srlr_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlr_chan_if
// Valid/ready channel carrying one payload struct per beat.
// ----------------------------------------------------------------------------
interface srlr_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/srlr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srlr_div
    import srlr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [7:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quotient
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_step;
    logic [7:0] r_rem;
    logic [7:0] r_quo;
    logic [7:0] r_div;
    logic [8:0] trial;
    logic       ge;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_quo[7]};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; a zero divisor divides as one.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= (i_divisor == 8'd0) ? 8'd1 : i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? 8'(trial - {1'b0, r_div}) : trial[7:0];
            r_quo <= {r_quo[6:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/stuffed_run_length_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_run_length_frame_receiver
// NRZ edge-event decoder with bit destuffing and byte packing.
// ----------------------------------------------------------------------------
// Usage:
//   i_edge takes one beat per line edge or timer timeout. o_byte gives the
//   bytes of the frame, each completed byte at once and a closing beat with
//   the partial byte when a frame ends; one item gives zero to two beats.
//   The configuration port writes bit_time_ticks (index 0) or idle_bits
//   (index 1) whenever i_cfg_we is high.
// Sequence:
//   An ignored edge is dropped in the idle state. A timeout goes from idle to
//   the drain state, which hands over its closing beat. A decoded edge starts
//   the eight-step divider that turns ticks into a bit count, then passes a
//   decision state, packs one run bit per cycle (up to 14) into the bit packer
//   and drains one result beat per cycle whenever the output register is free.
//   i_edge.ready is high only while the sequencer waits for an item.
// Reset and stall:
//   Reset clears the frame, sets the phase to idle and restores the register
//   defaults. A stalled o_byte holds its beat; the drain waits for it, and
//   one finished beat may sit in the output register while a new item is taken.
// ----------------------------------------------------------------------------
module stuffed_run_length_frame_receiver
    import srlr_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    srlr_chan_if.sink         i_edge,
    srlr_chan_if.source       o_byte
);

    localparam int CW = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam logic [CW-1:0] FRAME_FULL = CW'(FRAME_BUFFER_BYTES);

    // Configuration registers.
    logic [7:0] r_bt;
    logic [3:0] r_idle;

    // Receiver state.
    t_seq_state    r_state, n_state;
    t_phase        r_phase, n_phase;
    logic          r_prev, n_prev;
    logic [2:0]    r_bitpos, n_bitpos;
    logic [CW-1:0] r_bcnt, n_bcnt;
    logic [7:0]    r_acc, n_acc;
    logic          r_stuff, n_stuff;
    logic [3:0]    r_len, n_len;
    logic          r_bit, n_bit;
    logic [3:0]    r_cnt, n_cnt;

    // Results of the current item and the output register.
    t_qent         r_q [QDEPTH];
    t_qent         n_q [QDEPTH];
    logic [1:0]    r_qcnt, n_qcnt;
    logic [1:0]    r_rd, n_rd;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_odata, n_odata;

    logic          div_start;
    logic          div_done;
    logic [7:0]    quotient;
    t_in_item      in_item;

    assign in_item = i_edge.payload;

    srlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_item.elapsed_ticks),
        .i_divisor  (r_bt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Sequencer next state and datapath.
    always_comb begin
        logic [3:0] c;
        logic [7:0] acc_new;
        logic       full;
        logic       last;

        n_state   = r_state;
        n_phase   = r_phase;
        n_prev    = r_prev;
        n_bitpos  = r_bitpos;
        n_bcnt    = r_bcnt;
        n_acc     = r_acc;
        n_stuff   = r_stuff;
        n_len     = r_len;
        n_bit     = r_bit;
        n_cnt     = r_cnt;
        n_q       = r_q;
        n_qcnt    = r_qcnt;
        n_rd      = r_rd;
        n_ovalid  = r_ovalid & ~o_byte.ready;
        n_odata   = r_odata;
        div_start = 1'b0;
        c         = quotient[3:0];
        acc_new   = r_acc | (8'(r_bit) << r_bitpos);
        full      = (r_bcnt >= FRAME_FULL);
        last      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_edge.valid) begin
                    if (in_item.req_type == REQ_TIMEOUT) begin
                        // Timeout: close the frame and clear it.
                        n_phase = in_item.line_level ? PH_ERROR : PH_IDLE;
                        if (r_bcnt != '0 || r_bitpos != TOP_BIT) begin
                            n_q[0] = '{data_byte: r_acc, byte_index: 5'(r_bcnt),
                                       bits_valid: {1'b0, TOP_BIT - r_bitpos},
                                       frame_end: 1'b1, message_length: r_len};
                            n_qcnt = 2'd1;
                        end
                        n_bitpos = TOP_BIT;
                        n_bcnt   = '0;
                        n_acc    = '0;
                        n_stuff  = 1'b0;
                        n_len    = '0;
                        n_state  = ST_DRAIN;
                    end else if (in_item.line_level != r_prev && !full) begin
                        // A real edge: the run's value is the level before it.
                        n_prev    = in_item.line_level;
                        n_bit     = ~in_item.line_level;
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_state = ST_DRAIN;
                if (quotient >= {4'd0, r_idle}) begin
                    // Idle-length run.
                    n_phase = r_bit ? PH_ERROR : PH_IDLE;
                end else if (r_phase == PH_IDLE && !r_bit) begin
                    n_phase = r_phase;
                end else begin
                    n_state = ST_BITS;
                    // Start of frame: close any pending frame first.
                    if (r_phase == PH_IDLE) begin
                        if (r_bcnt != '0 || r_bitpos != TOP_BIT) begin
                            n_q[0] = '{data_byte: r_acc, byte_index: 5'(r_bcnt),
                                       bits_valid: {1'b0, TOP_BIT - r_bitpos},
                                       frame_end: 1'b1, message_length: r_len};
                            n_qcnt = 2'd1;
                        end
                        n_bitpos = TOP_BIT;
                        n_bcnt   = '0;
                        n_acc    = '0;
                        n_stuff  = 1'b0;
                        n_len    = '0;
                        n_phase  = PH_START;
                    end
                    if (c == 4'd0) begin
                        n_state = ST_DRAIN;
                    end else begin
                        // Drop the start bit of the first run.
                        if (n_phase == PH_START) begin
                            c       = c - 4'd1;
                            n_phase = PH_MSG;
                        end
                        // Drop a stuffed bit after a five-bit run.
                        if (n_stuff) begin
                            if (c < STUFF_LIMIT && c != 4'd0) begin
                                c = c - 4'd1;
                            end
                            n_stuff = 1'b0;
                        end
                        if (c == STUFF_RUN) begin
                            n_stuff = 1'b1;
                        end
                    end
                    n_cnt = c;
                end
            end

            ST_BITS: begin
                // One run bit per cycle into the byte accumulator.
                if (r_cnt == 4'd0 || full) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                    if (r_bitpos == 3'd0) begin
                        if (r_bcnt == '0) begin
                            n_len   = 4'(acc_new & LEN_MASK);
                            n_phase = PH_LEN;
                        end
                        n_q[r_qcnt] = '{data_byte: acc_new, byte_index: 5'(r_bcnt),
                                        bits_valid: FULL_BITS, frame_end: 1'b0,
                                        message_length: n_len};
                        n_qcnt   = r_qcnt + 2'd1;
                        n_bcnt   = r_bcnt + CW'(1);
                        n_acc    = '0;
                        n_bitpos = TOP_BIT;
                    end else begin
                        n_acc    = acc_new;
                        n_bitpos = r_bitpos - 3'd1;
                    end
                end
            end

            ST_DRAIN: begin
                // Hand the item's results to the output register in order.
                if (r_qcnt == 2'd0) begin
                    n_state = ST_IDLE;
                end else if (!r_ovalid || o_byte.ready) begin
                    last     = (r_rd == r_qcnt - 2'd1);
                    n_odata  = '{data_byte: r_q[r_rd].data_byte,
                                 byte_index: r_q[r_rd].byte_index,
                                 bits_valid: r_q[r_rd].bits_valid,
                                 frame_end: r_q[r_rd].frame_end,
                                 message_length: r_q[r_rd].message_length,
                                 receive_state: r_phase,
                                 last_in_run: last};
                    n_ovalid = 1'b1;
                    n_rd     = r_rd + 2'd1;
                    if (last) begin
                        n_rd    = '0;
                        n_qcnt  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt   <= BIT_TIME_RST;
            r_idle <= IDLE_BITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIT_TIME:  r_bt   <= i_cfg_data;
                CFG_IDLE_BITS: r_idle <= i_cfg_data[3:0];
                default:       r_bt   <= r_bt;
            endcase
        end
    end

    // Control and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_IDLE;
            r_prev   <= 1'b0;
            r_bitpos <= TOP_BIT;
            r_bcnt   <= '0;
            r_acc    <= '0;
            r_stuff  <= 1'b0;
            r_len    <= '0;
            r_qcnt   <= '0;
            r_rd     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_bitpos <= n_bitpos;
            r_bcnt   <= n_bcnt;
            r_acc    <= n_acc;
            r_stuff  <= n_stuff;
            r_len    <= n_len;
            r_qcnt   <= n_qcnt;
            r_rd     <= n_rd;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bit   <= n_bit;
        r_cnt   <= n_cnt;
        r_q     <= n_q;
        r_odata <= n_odata;
    end

    assign i_edge.ready   = (r_state == ST_IDLE);
    assign o_byte.valid   = r_ovalid;
    assign o_byte.payload = r_odata;

endmodule

// File: sim/stuffed_run_length_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_run_length_frame_receiver_tb
// Self-checking bench for the NRZ edge-event frame receiver. A scoreboard
// class decodes every accepted edge or timeout beat into the byte beats it
// should produce. The bench compares each received beat field by field, in
// order. The stimulus starts with a short directed sequence. Random frames
// follow under several bit-time and idle-threshold settings, with noise,
// full frames, random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module stuffed_run_length_frame_receiver_tb;
    import srlr_pkg::*;

    localparam int FRAME_BYTES    = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 51;

    // Special traffic that a configuration phase adds to its random frames.
    typedef enum {
        PLAIN_RUN,
        FULL_FRAME_RUN,
        NO_STALL_RUN,
        BACKPRESSURE_RUN,
        SENDER_PAUSE_RUN
    } t_extra;

    // Decodes accepted edge beats and holds the byte beats still to arrive.
    class rx_byte_scoreboard;
        logic [7:0]  bit_time;
        logic [3:0]  idle_bits;
        logic        prev_level;
        t_phase      rx_state;
        logic [2:0]  bit_pos;
        int unsigned byte_cnt;
        logic [7:0]  acc;
        logic        stuff_pend;
        logic [3:0]  len_nib;
        t_out_item   expected[$];
        t_out_item   item_beats[$];
        int          errors;

        function new();
            bit_time   = BIT_TIME_RST;
            idle_bits  = IDLE_BITS_RST;
            prev_level = 1'b0;
            rx_state   = PH_IDLE;
            errors     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            bit_pos    = TOP_BIT;
            byte_cnt   = 0;
            acc        = '0;
            stuff_pend = 1'b0;
            len_nib    = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] value);
            if (idx == CFG_BIT_TIME) begin
                bit_time = value;
            end else begin
                idle_bits = value[3:0];
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void emit(logic [7:0] data, logic [3:0] bits, logic fin);
            t_out_item b;
            b                = '0;
            b.data_byte      = data;
            b.byte_index     = 5'(byte_cnt);
            b.bits_valid     = bits;
            b.frame_end      = fin;
            b.message_length = len_nib;
            item_beats.push_back(b);
        endfunction

        // A frame holding any bits gives one closing beat with the partial byte.
        function void close_frame();
            if (byte_cnt == 0 && bit_pos == TOP_BIT) begin
                return;
            end
            emit(acc, 4'(TOP_BIT - bit_pos), 1'b1);
            clear_frame();
        endfunction

        // Note one accepted input beat and queue the byte beats it causes.
        function void take_item(t_in_item it);
            int unsigned div;
            int unsigned run;
            logic        bitv;
            item_beats.delete();
            if (it.req_type == REQ_TIMEOUT) begin
                rx_state = it.line_level ? PH_ERROR : PH_IDLE;
                close_frame();
            end else if (it.line_level != prev_level && byte_cnt < FRAME_BYTES) begin
                prev_level = it.line_level;
                bitv       = ~it.line_level;
                div        = (bit_time == 8'd0) ? 1 : bit_time;
                run        = it.elapsed_ticks / div;
                if (run >= idle_bits) begin
                    // A long run marks the line idle; high means a stuck bus.
                    rx_state = bitv ? PH_ERROR : PH_IDLE;
                end else if (rx_state != PH_IDLE || bitv) begin
                    // The end of a high run in idle opens a new frame.
                    if (rx_state == PH_IDLE) begin
                        close_frame();
                        clear_frame();
                        rx_state = PH_START;
                    end
                    if (run > 0) begin
                        // The first run of a frame carries the start bit.
                        if (rx_state == PH_START) begin
                            run--;
                            rx_state = PH_MSG;
                        end
                        // A run of five is followed by one stuffed bit.
                        if (stuff_pend) begin
                            if (run > 0 && run < STUFF_LIMIT) begin
                                run--;
                            end
                            stuff_pend = 1'b0;
                        end
                        if (run == STUFF_RUN) begin
                            stuff_pend = 1'b1;
                        end
                        // Pack the run MSB first; bits beyond a full frame are lost.
                        while (run > 0 && byte_cnt < FRAME_BYTES) begin
                            if (bitv) begin
                                acc[bit_pos] = 1'b1;
                            end
                            if (bit_pos == 3'd0) begin
                                if (byte_cnt == 0) begin
                                    len_nib  = 4'(acc & LEN_MASK);
                                    rx_state = PH_LEN;
                                end
                                emit(acc, FULL_BITS, 1'b0);
                                byte_cnt++;
                                acc     = '0;
                                bit_pos = TOP_BIT;
                            end else begin
                                bit_pos--;
                            end
                            run--;
                        end
                    end
                end
            end
            // Every beat of the item reports the phase after the whole item.
            foreach (item_beats[k]) begin
                item_beats[k].receive_state = rx_state;
                item_beats[k].last_in_run   = (k == item_beats.size() - 1);
                expected.push_back(item_beats[k]);
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t ns: byte beat %s expected %0d actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // Compare one received byte beat with the oldest expected one.
        function void check_beat(t_out_item got);
            t_out_item want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t ns: byte beat with none expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = expected.pop_front();
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("byte_index", want.byte_index, got.byte_index);
            check_field("bits_valid", want.bits_valid, got.bits_valid);
            check_field("frame_end", want.frame_end, got.frame_end);
            check_field("message_length", want.message_length, got.message_length);
            check_field("receive_state", want.receive_state, got.receive_state);
            check_field("last_in_run", want.last_in_run, got.last_in_run);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_idx   i_cfg_idx;
    logic [7:0] i_cfg_data;

    srlr_chan_if #(.T(t_in_item))  edge_ch ();
    srlr_chan_if #(.T(t_out_item)) byte_ch ();

    rx_byte_scoreboard board;
    logic [7:0]        cur_bt;
    logic [3:0]        cur_idle;
    logic              line_lvl;
    int                items_sent;
    bit                no_stall;
    bit                hold_req;

    stuffed_run_length_frame_receiver #(
        .FRAME_BUFFER_BYTES(FRAME_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (edge_ch),
        .o_byte     (byte_ch)
    );

    // Clock with a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Byte receiver: checks each beat, stalls at random, holds off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        byte_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (byte_ch.valid && byte_ch.ready) begin
                board.check_beat(byte_ch.payload);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end else begin
                byte_ch.ready <= no_stall || ($urandom_range(99) >= 7);
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((edge_ch.valid && edge_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("stuffed_run_length_frame_receiver regression: fail");
        $finish;
    end

    function automatic int unsigned bt_eff();
        return (cur_bt == 8'd0) ? 1 : cur_bt;
    endfunction

    // Longest run that stays below the idle threshold and fits in the ticks.
    function automatic int unsigned longest_run();
        int unsigned lim;
        lim = 255 / bt_eff();
        if (cur_idle == 4'd0) begin
            return 0;
        end
        return (cur_idle - 1 < lim) ? cur_idle - 1 : lim;
    endfunction

    // Run length in bits, leaning toward the destuffing lengths.
    function automatic int unsigned pick_len(bit long_runs);
        int unsigned top;
        int          r;
        top = longest_run();
        r   = $urandom_range(99);
        if (top == 0) begin
            return 0;
        end
        if (long_runs) begin
            return $urandom_range(top, (top > 3) ? top - 3 : 1);
        end
        if (r < 25 && top >= STUFF_RUN) begin
            return STUFF_RUN;
        end
        if (r < 35 && top >= STUFF_LIMIT) begin
            return STUFF_LIMIT;
        end
        return $urandom_range(top, 1);
    endfunction

    // Offer one input beat, after a random gap, and wait until it is taken.
    task automatic send_item(input t_in_item it);
        if (!no_stall && $urandom_range(99) < 7) begin
            edge_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        edge_ch.valid   <= 1'b1;
        edge_ch.payload <= it;
        do @(posedge i_clk); while (!edge_ch.ready);
        board.take_item(it);
        items_sent++;
    endtask

    task automatic send_edge(input logic lvl, input int unsigned ticks);
        t_in_item it;
        it.req_type      = REQ_EDGE;
        it.line_level    = lvl;
        it.elapsed_ticks = (ticks > 255) ? 8'd255 : 8'(ticks);
        send_item(it);
        line_lvl = lvl;
    endtask

    task automatic send_timeout(input logic lvl);
        t_in_item it;
        it.req_type      = REQ_TIMEOUT;
        it.line_level    = lvl;
        it.elapsed_ticks = 8'($urandom_range(255));
        send_item(it);
    endtask

    // Toggle the line after a run of nbits bit times plus some jitter.
    task automatic send_run(input int unsigned nbits);
        send_edge(~line_lvl, nbits * bt_eff() + $urandom_range(bt_eff() - 1));
    endtask

    task automatic send_idle_run();
        send_edge(~line_lvl, cur_idle * bt_eff() + $urandom_range(bt_eff() - 1));
    endtask

    task automatic noise_item();
        t_in_item it;
        it.req_type      = ($urandom_range(99) < 20) ? REQ_TIMEOUT : REQ_EDGE;
        it.line_level    = 1'($urandom_range(1));
        it.elapsed_ticks = 8'($urandom_range(255));
        send_item(it);
        if (it.req_type == REQ_EDGE) begin
            line_lvl = it.line_level;
        end
    endtask

    // One frame on the wire: settle idle, start run, data runs, then usually a close.
    task automatic frame_seq(input int n_runs, input bit long_runs);
        int r;
        if (line_lvl == 1'b0 && $urandom_range(1)) begin
            send_idle_run();
        end else begin
            send_timeout(1'b0);
        end
        if (line_lvl == 1'b0) begin
            send_run(pick_len(1'b0));
        end
        send_run(pick_len(1'b0));
        for (int k = 0; k < n_runs; k++) begin
            // Now and then a glitch that repeats the current level.
            if ($urandom_range(99) < 4) begin
                send_edge(line_lvl, $urandom_range(255));
            end
            send_run(pick_len(long_runs));
        end
        r = $urandom_range(99);
        if (r < 50 || long_runs) begin
            send_timeout(1'($urandom_range(1)));
        end else if (r < 80) begin
            send_idle_run();
        end
    endtask

    // Stop offering input until every expected beat has arrived.
    task automatic pause_for_results();
        edge_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic wait_drain();
        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; the block is idle here.
    task automatic configure(input logic [7:0] bt, input logic [3:0] ib);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BIT_TIME;
        i_cfg_data <= bt;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDLE_BITS;
        i_cfg_data <= {4'($urandom_range(15)), ib};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(CFG_BIT_TIME, bt);
        board.write_reg(CFG_IDLE_BITS, {4'h0, ib});
        cur_bt   = bt;
        cur_idle = ib;
    endtask

    task automatic run_phase(input logic [7:0] bt, input logic [3:0] ib,
                             input t_extra extra);
        int start;
        int r;
        bit done_extra;
        wait_drain();
        configure(bt, ib);
        start      = items_sent;
        done_extra = 1'b0;
        no_stall   = (extra == NO_STALL_RUN);
        if (extra == FULL_FRAME_RUN) begin
            frame_seq(30, 1'b1);
        end
        while (items_sent - start < PHASE_ITEMS) begin
            if (!done_extra && items_sent - start >= 20) begin
                if (extra == BACKPRESSURE_RUN) begin
                    hold_req   = 1'b1;
                    done_extra = 1'b1;
                end else if (extra == SENDER_PAUSE_RUN) begin
                    pause_for_results();
                    done_extra = 1'b1;
                end
            end
            r = $urandom_range(99);
            if (r < 70) begin
                frame_seq($urandom_range(10, 1), 1'b0);
            end else if (r < 85) begin
                noise_item();
            end else if (r < 92) begin
                send_timeout(1'($urandom_range(1)));
            end else if (r < 96) begin
                send_run(pick_len(1'b0));
            end else begin
                frame_seq($urandom_range(20, 12), 1'b1);
            end
        end
        no_stall = 1'b0;
    endtask

    // Main sequence: reset, directed beats, configuration phases, final check.
    initial begin
        board      = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BIT_TIME;
        i_cfg_data <= '0;
        edge_ch.valid   <= 1'b0;
        edge_ch.payload <= '0;
        cur_bt     = BIT_TIME_RST;
        cur_idle   = IDLE_BITS_RST;
        line_lvl   = 1'b0;
        items_sent = 0;
        no_stall   = 1'b0;
        hold_req   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings: 20 ticks per bit, idle at 7 bits.
        send_edge(1'b1, 255);   // long low run: line idle
        send_edge(1'b1, 0);     // same level again: ignored
        send_edge(1'b0, 40);    // high run opens a frame, start bit dropped
        send_edge(1'b1, 100);   // five zeros arm the destuffing
        send_edge(1'b0, 60);    // three ones lose the stuffed bit, first byte done
        send_edge(1'b1, 19);    // run shorter than one bit
        send_edge(1'b0, 255);   // long high run: error phase
        send_edge(1'b1, 60);    // short run still appended in error
        send_timeout(1'b0);     // closes the partial byte
        send_timeout(1'b1);     // empty frame: no beat
        send_edge(1'b0, 20);    // one bit appended in error
        send_edge(1'b1, 255);   // idle again, frame kept
        send_edge(1'b0, 20);    // new start closes the pending frame
        send_edge(1'b1, 139);   // six zeros
        send_timeout(1'b0);

        run_phase(8'd20, 4'd7, PLAIN_RUN);
        run_phase(8'd1, 4'd15, FULL_FRAME_RUN);
        run_phase(8'd255, 4'd1, PLAIN_RUN);
        run_phase(8'd0, 4'd15, FULL_FRAME_RUN);
        run_phase(8'd8, 4'd5, NO_STALL_RUN);
        run_phase(8'd17, 4'd15, BACKPRESSURE_RUN);
        run_phase(8'd3, 4'd10, SENDER_PAUSE_RUN);
        wait_drain();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("stuffed_run_length_frame_receiver regression: pass");
        end else begin
            $display("stuffed_run_length_frame_receiver regression: fail");
        end
        $finish;
    end

endmodule
